### rtl/bhpq_pkg.sv
// Package for the binary heap priority queue: command and status codes,
// widths and the controller/datapath command and status structs. No dependencies.
package bhpq_pkg;
    localparam int DEFAULT_CAPACITY = 1024;
    localparam int DEFAULT_KEY_BITS = 32;
    localparam int FIELD_KEY_W = 32;
    localparam int COUNT_W = 11;

    localparam logic [1:0] MODE_PUSH    = 2'd0;
    localparam logic [1:0] MODE_POP     = 2'd1;
    localparam logic [1:0] MODE_REPLACE = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [0:0] REG_HEAP_KIND  = 1'd0;
    localparam logic [0:0] REG_KEY_SIGNED = 1'd1;

    // Datapath operations issued by the controller.
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1; // latch item, apply count, fetch root and last
    localparam logic [2:0] OP_LOAD    = 3'd2; // take removed root and sinking key
    localparam logic [2:0] OP_READ    = 3'd3; // read parent or both children
    localparam logic [2:0] OP_COMPARE = 3'd4; // compare, write one entry, move
    localparam logic [2:0] OP_RDTOP   = 3'd5; // read root for the result
    localparam logic [2:0] OP_FINISH  = 3'd6; // load output register

    typedef struct packed {
        logic [2:0] op;
    } bhpq_cmd_t;

    typedef struct packed {
        logic stop;     // sift finished
    } bhpq_stat_t;
endpackage

### rtl/bhpq_datapath.sv
// Datapath of the heap: key memory, index and count registers, comparator
// and result register. Depends on bhpq_pkg.
module bhpq_datapath #(
    parameter int CAPACITY = bhpq_pkg::DEFAULT_CAPACITY,
    parameter int KEY_BITS = bhpq_pkg::DEFAULT_KEY_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bhpq_pkg::bhpq_cmd_t                 cmd,
    output bhpq_pkg::bhpq_stat_t                stat,
    input  logic [1:0]                          in_mode,
    input  logic [bhpq_pkg::FIELD_KEY_W-1:0]    in_key,
    input  logic                                heap_kind,
    input  logic                                key_signed,
    output logic [bhpq_pkg::FIELD_KEY_W-1:0]    out_removed,
    output logic [bhpq_pkg::FIELD_KEY_W-1:0]    out_top,
    output logic [bhpq_pkg::COUNT_W-1:0]        out_count,
    output logic [1:0]                          out_status
);
    import bhpq_pkg::*;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2; // room for 2*i+2

    logic [KEY_BITS-1:0] mem [CAPACITY];
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [1:0]          mode_reg, mode_next;
    logic [1:0]          status_reg, status_next;
    logic                stop_reg, stop_next;
    logic [KEY_BITS-1:0] cur_reg, cur_next;
    logic [KEY_BITS-1:0] removed_reg, removed_next;
    logic [KEY_BITS-1:0] rd0_reg, rd1_reg;
    logic                re;
    logic [AW-1:0]       raddr0, raddr1;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [KEY_BITS-1:0] wdata;
    logic [AW-1:0]       parent;
    logic [IW-1:0]       lchild, rchild, count_ext;
    logic                has_l, has_r, take_r;
    logic [AW-1:0]       pick;
    logic [KEY_BITS-1:0] pick_key;
    logic [KEY_BITS-1:0] new_key;

    function automatic logic above(input logic [KEY_BITS-1:0] x,
                                   input logic [KEY_BITS-1:0] y,
                                   input logic kind, input logic sgn);
        logic [KEY_BITS-1:0] xa, ya;
        xa = x; ya = y;
        if (sgn) begin
            xa[KEY_BITS-1] = ~x[KEY_BITS-1];
            ya[KEY_BITS-1] = ~y[KEY_BITS-1];
        end
        return kind ? (xa < ya) : (xa > ya);
    endfunction

    assign new_key   = KEY_BITS'(in_key);
    assign parent    = (idx_reg - AW'(1)) >> 1;
    assign lchild    = {1'b0, idx_reg, 1'b1};
    assign rchild    = lchild + IW'(1);
    assign count_ext = IW'(count_reg);
    assign has_l     = lchild < count_ext;
    assign has_r     = rchild < count_ext;
    assign take_r    = has_r && above(rd1_reg, rd0_reg, heap_kind, key_signed);
    assign pick      = take_r ? AW'(rchild) : AW'(lchild);
    assign pick_key  = take_r ? rd1_reg : rd0_reg;

    assign stat.stop = stop_reg;

    // The sifting key stays in cur_reg and the hole moves, so each level
    // writes one entry and the key lands once the walk stops.
    always_comb begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        mode_next    = mode_reg;
        status_next  = status_reg;
        stop_next    = stop_reg;
        cur_next     = cur_reg;
        removed_next = removed_reg;
        re = 1'b0; raddr0 = '0; raddr1 = '0;
        we = 1'b0; waddr = idx_reg; wdata = cur_reg;
        unique case (cmd.op)
            OP_START: begin
                mode_next    = in_mode;
                status_next  = ST_DONE;
                removed_next = '0;
                stop_next    = 1'b0;
                idx_next     = '0;
                // Fetch the root and the last entry for pop and replace.
                re     = 1'b1;
                raddr1 = AW'(count_reg - CW'(1));
                case (in_mode)
                    MODE_PUSH: begin
                        if (count_reg >= CW'(CAPACITY)) begin
                            status_next = ST_FULL; stop_next = 1'b1;
                        end else begin
                            cur_next   = new_key;
                            idx_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    MODE_POP: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY; stop_next = 1'b1;
                        end else begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    MODE_REPLACE: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY; stop_next = 1'b1;
                        end else begin
                            cur_next = new_key;
                        end
                    end
                    default: begin
                        count_next = '0; stop_next = 1'b1;
                    end
                endcase
            end
            OP_LOAD: begin
                if (status_reg == ST_DONE) begin
                    case (mode_reg)
                        MODE_POP: begin
                            removed_next = rd0_reg;
                            cur_next     = rd1_reg;
                        end
                        MODE_REPLACE: removed_next = rd0_reg;
                        default: ;
                    endcase
                end
            end
            OP_READ: begin
                re = 1'b1;
                if (mode_reg == MODE_PUSH) begin
                    raddr0 = parent;
                end else begin
                    raddr0 = AW'(lchild);
                    raddr1 = AW'(rchild);
                end
            end
            OP_COMPARE: begin
                we = 1'b1;
                if (mode_reg == MODE_PUSH) begin
                    if (idx_reg == '0 || !above(cur_reg, rd0_reg, heap_kind, key_signed)) begin
                        stop_next = 1'b1;
                    end else begin
                        wdata    = rd0_reg;
                        idx_next = parent;
                    end
                end else begin
                    if (!has_l || !above(pick_key, cur_reg, heap_kind, key_signed)) begin
                        stop_next = 1'b1;
                    end else begin
                        wdata    = pick_key;
                        idx_next = pick;
                    end
                end
            end
            OP_RDTOP: begin
                re     = 1'b1;
                raddr0 = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            idx_reg     <= '0;
            mode_reg    <= MODE_PUSH;
            status_reg  <= ST_DONE;
            stop_reg    <= 1'b0;
            cur_reg     <= '0;
            removed_reg <= '0;
        end else begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            mode_reg    <= mode_next;
            status_reg  <= status_next;
            stop_reg    <= stop_next;
            cur_reg     <= cur_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) begin
            rd0_reg <= mem[raddr0];
            rd1_reg <= mem[raddr1];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FINISH) begin
            out_removed <= FIELD_KEY_W'(removed_reg);
            out_top     <= (count_reg != '0) ? FIELD_KEY_W'(rd0_reg) : '0;
            out_count   <= COUNT_W'(count_reg);
            out_status  <= status_reg;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY)) else $error("entry count out of range");
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(we && re)) else $error("memory read and write in one cycle");
endmodule

### rtl/bhpq_ctrl.sv
// Controller state machine of the heap: runs the sift loop and the stream
// handshakes. Depends on bhpq_pkg.
module bhpq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output bhpq_pkg::bhpq_cmd_t  cmd,
    input  bhpq_pkg::bhpq_stat_t stat
);
    import bhpq_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_LOAD = 3'd1, S_RD = 3'd2,
                           S_CMP = 3'd3, S_FIN = 3'd4;
    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       fin;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign fin = (state_reg == S_FIN) && (!mvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) begin
                cmd.op = OP_START; state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.op = OP_LOAD; state_next = S_RD;
            end
            S_RD: begin
                if (stat.stop) begin
                    state_next = S_FIN; cmd.op = OP_RDTOP;
                end else begin
                    cmd.op = OP_READ; state_next = S_CMP;
                end
            end
            S_CMP: begin
                cmd.op = OP_COMPARE; state_next = S_RD;
            end
            S_FIN: if (fin) begin
                cmd.op = OP_FINISH; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        mvalid_next = fin ? 1'b1 : (mvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    a_fin_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fin |=> m_tvalid) else $error("result not presented");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("accepted while busy");
    a_cmp_from_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> $past(state_reg) == S_RD) else $error("bad sift order");
endmodule

### rtl/binary_heap_priority_queue_core.sv
// Channel  | Dir | Fields
// s_       | in  | tdata[1:0]=mode, tdata[33:2]=key
// m_       | out | tdata: removed_key, top_key, entry_count, status
// cfg      | in  | APB: 0x0 heap_kind, 0x4 key_signed
// An item runs through start, load, a read of the root and finish; for each level
// the sift visits it adds a registered memory read and then a compare and write.
// A push climbs at most ten levels of a 1024-entry heap.
// Reset is synchronous, active low; it empties the heap. A result waits in the
// output register, and the next item is taken once it has been moved there.
module binary_heap_priority_queue_core #(
    parameter int CAPACITY = bhpq_pkg::DEFAULT_CAPACITY,
    parameter int KEY_BITS = bhpq_pkg::DEFAULT_KEY_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], key[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // removed_key, top_key, entry_count, status, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bhpq_pkg::*;
    logic kind_reg, sgn_reg;
    bhpq_cmd_t  cmd;
    bhpq_stat_t stat;
    logic [31:0] rm, tp;
    logic [10:0] cnt;
    logic [1:0]  st;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= 1'b0; sgn_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HEAP_KIND) kind_reg <= pwdata[0];
            if (paddr[2] == REG_KEY_SIGNED) sgn_reg <= pwdata[0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_KEY_SIGNED) prdata[0] = sgn_reg;
        else prdata[0] = kind_reg;
    end

    bhpq_ctrl u_ctrl (.aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
                      .cmd, .stat);
    bhpq_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .in_mode(s_tdata[1:0]), .in_key(s_tdata[33:2]),
        .heap_kind(kind_reg), .key_signed(sgn_reg), .out_removed(rm), .out_top(tp),
        .out_count(cnt), .out_status(st));
    assign m_tdata = {3'b0, st, cnt, tp, rm};
endmodule
